// ----- rtl/infix_expression_evaluator_macros.svh -----
// Assertion macros for the infix expression evaluator.
// Used by the top level; no other dependencies.
`ifndef INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// same-cycle implication
`define IEE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IEE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/iee_pkg.sv -----
// Shared types, constants and the precedence table of the infix evaluator.
// No dependencies.
package iee_pkg;

   function automatic logic [63:0] ten_pow(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int k = 0; k < n; k++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

   localparam int VW         = 48;
   localparam int FB         = 16;
   localparam int MAX_DIGITS = 15;
   localparam logic [63:0] TEN_MAX = ten_pow(MAX_DIGITS);
   localparam int MANT_W     = $clog2(TEN_MAX);
   localparam int FD_W       = $clog2(MAX_DIGITS + 1);
   localparam int DW         = (MANT_W > VW) ? MANT_W : VW;
   localparam int NW         = DW + FB;
   localparam int PW         = 2 * DW;

   localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

   typedef enum logic [3:0] {
      K_DIGIT, K_POINT, K_PLUS, K_MINUS, K_TIMES, K_DIVIDE,
      K_LPAR, K_RPAR, K_EQUALS, K_CLEAR
   } kind_type;

   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LPAR, OP_RPAR, OP_END
   } op_type;

   typedef enum logic [1:0] {REL_LT, REL_EQ, REL_GT, REL_NO} rel_type;

   typedef enum logic [1:0] {ST_OK, ST_REJECT, ST_FULL, ST_DIVZERO} status_type;

   typedef enum logic {MD_MUL, MD_DIV} mdu_mode_type;

   typedef struct packed {
      logic       take;
      logic       digit_load;
      logic       num_clear;
      logic       point_set;
      logic       clear_all;
      logic       conv_start;
      logic       conv_push;
      logic       top_read;
      logic       op_push;
      logic       op_pop;
      logic       num_pop;
      logic       num_peek;
      logic       load_a;
      logic       load_b;
      logic       alu_start;
      logic       res_push;
      logic       paren_inc;
      logic       paren_dec;
      logic       rsp_load;
      logic       rsp_valid;
      status_type code;
      op_type     tok;
   } dp_cmd_type;

   typedef struct packed {
      logic   dv_bad;
      logic   nm_ovf;
      logic   fd_full;
      logic   point;
      logic   active;
      logic   op_full;
      logic   num_full;
      logic   parens_zero;
      logic   res_rdy;
      op_type top;
   } dp_stat_type;

   // rows: stack top, columns: incoming token
   function automatic rel_type prec(input op_type top, input op_type tok);
      rel_type r;
      case (top)
         OP_ADD, OP_SUB: begin
            r = (tok == OP_MUL || tok == OP_DIV || tok == OP_LPAR) ? REL_LT : REL_GT;
         end
         OP_MUL, OP_DIV: begin
            r = (tok == OP_LPAR) ? REL_LT : REL_GT;
         end
         OP_LPAR: begin
            r = (tok == OP_RPAR) ? REL_EQ : ((tok == OP_END) ? REL_NO : REL_LT);
         end
         OP_RPAR: begin
            r = (tok == OP_LPAR) ? REL_NO : REL_GT;
         end
         OP_END: begin
            r = (tok == OP_RPAR) ? REL_NO : ((tok == OP_END) ? REL_EQ : REL_LT);
         end
         default: begin
            r = REL_NO;
         end
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/iee_if.sv -----
// Request and response channel interfaces of the infix evaluator.
// Depends on iee_pkg for the value width.
interface iee_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] kind;
   logic [3:0] digit_value;
   modport source (output valid, kind, digit_value, input ready);
   modport sink (input valid, kind, digit_value, output ready);
endinterface

interface iee_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic                           result_valid;
   logic signed [iee_pkg::VW-1:0]  result_value;
   logic [5:0]                     open_paren_count;
   modport source (output valid, status, result_valid, result_value, open_paren_count,
                   input ready);
   modport sink (input valid, status, result_valid, result_value, open_paren_count,
                 output ready);
endinterface

// ----- rtl/iee_mdu.sv -----
// Iterative multiply / divide unit, one bit per cycle, with rounding.
// Depends on iee_pkg.
module iee_mdu (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  iee_pkg::mdu_mode_type      mode,
   input  logic [iee_pkg::DW-1:0]     a_in,
   input  logic [iee_pkg::DW-1:0]     b_in,
   output logic                       done,
   output logic                       ge,
   output logic [iee_pkg::VW-2:0]     mag
);
   import iee_pkg::*;

   localparam int CNT_W = $clog2(NW + 1);
   localparam logic [PW:0] HALF = (PW+1)'(1) << (FB - 1);

   logic               busy_ff;
   mdu_mode_type       mode_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NW-1:0]      n_ff;
   logic [DW-1:0]      d_ff;
   logic [DW-1:0]      rem_ff;
   logic [VW-1:0]      q_ff;
   logic               big_ff;
   logic [PW-1:0]      acc_ff;
   logic               done_ff;
   logic               ge_ff;
   logic [VW-2:0]      mag_ff;

   logic [DW:0]        rem2;
   logic               sub_ok;
   logic [DW-1:0]      rem_next;
   logic [PW-1:0]      acc_next;
   logic               rnd;
   logic [VW:0]        qsum;
   logic [PW:0]        rsum;
   logic [PW:0]        rsh;

   always_comb begin
      rem2     = {rem_ff, n_ff[NW-1]};
      sub_ok   = rem2 >= {1'b0, d_ff};
      rem_next = sub_ok ? DW'(rem2 - {1'b0, d_ff}) : DW'(rem2);
      acc_next = {acc_ff[PW-2:0], 1'b0} + (d_ff[DW-1] ? PW'(n_ff[DW-1:0]) : '0);
      rnd      = {rem_ff, 1'b0} >= {1'b0, d_ff};
      qsum     = {1'b0, q_ff} + (VW+1)'(rnd);
      rsum     = {1'b0, acc_ff} + HALF;
      rsh      = rsum >> FB;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            mode_ff <= mode;
            cnt_ff  <= (mode == MD_DIV) ? CNT_W'(NW) : CNT_W'(DW);
            n_ff    <= (mode == MD_DIV) ? {a_in, {FB{1'b0}}} : NW'(a_in);
            d_ff    <= b_in;
            rem_ff  <= '0;
            q_ff    <= '0;
            big_ff  <= 1'b0;
            acc_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               cnt_ff <= cnt_ff - 1'b1;
               if (mode_ff == MD_DIV) begin
                  rem_ff <= rem_next;
                  n_ff   <= n_ff << 1;
                  big_ff <= big_ff | q_ff[VW-1];
                  q_ff   <= {q_ff[VW-2:0], sub_ok};
               end else begin
                  acc_ff <= acc_next;
                  d_ff   <= d_ff << 1;
               end
            end else begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               if (mode_ff == MD_DIV) begin
                  ge_ff  <= big_ff | (|qsum[VW:VW-1]);
                  mag_ff <= qsum[VW-2:0];
               end else begin
                  ge_ff  <= |rsh[PW:VW-1];
                  mag_ff <= rsh[VW-2:0];
               end
            end
         end
      end
   end

   assign done = done_ff;
   assign ge   = ge_ff;
   assign mag  = mag_ff;

endmodule

// ----- rtl/iee_dp.sv -----
// Datapath: number entry, operator and number stacks, ALU, response register.
// Depends on iee_pkg and iee_mdu.
module iee_dp #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [3:0]                    req_digit_value,
   input  iee_pkg::dp_cmd_type           cmd,
   output iee_pkg::dp_stat_type          stat,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_result_valid,
   output logic signed [iee_pkg::VW-1:0] rsp_result_value,
   output logic [5:0]                    rsp_open_paren_count
);
   import iee_pkg::*;

   localparam int AW   = $clog2(STACK_DEPTH);
   localparam int CW   = $clog2(STACK_DEPTH + 1);
   localparam int NM_W = MANT_W + 4;

   logic [3:0]            dv_ff;
   logic [MANT_W-1:0]     mant_ff;
   logic [MANT_W-1:0]     pow_ff;
   logic [FD_W-1:0]       fd_ff;
   logic                  point_ff;
   logic                  active_ff;
   logic [CW-1:0]         opc_ff;
   logic [CW-1:0]         numc_ff;
   logic [CW-1:0]         parens_ff;
   op_type                op_mem [STACK_DEPTH];
   op_type                op_rd_ff;
   logic signed [VW-1:0]  num_mem [STACK_DEPTH];
   logic signed [VW-1:0]  num_rd_ff;
   logic                  empty_ff;
   logic signed [VW-1:0]  a_ff;
   logic signed [VW-1:0]  b_ff;
   logic signed [VW-1:0]  res_ff;
   logic                  res_rdy_ff;
   logic                  neg_ff;
   logic                  dz_ff;
   status_type            st_ff;
   logic                  rv_ff;
   logic signed [VW-1:0]  val_ff;
   logic [5:0]            par_out_ff;

   logic [NM_W-1:0]       nm;
   op_type                top;
   logic [VW-1:0]         mag_a;
   logic [VW-1:0]         mag_b;
   logic signed [VW:0]    sum_add;
   logic signed [VW:0]    sum_sub;
   logic signed [VW-1:0]  sat_add;
   logic signed [VW-1:0]  sat_sub;
   logic signed [VW-1:0]  dz_val;
   logic                  push_en;
   logic                  mdu_start;
   mdu_mode_type          mdu_mode;
   logic [DW-1:0]         mdu_a;
   logic [DW-1:0]         mdu_b;
   logic                  mdu_done;
   logic                  mdu_ge;
   logic [VW-2:0]         mdu_mag;
   logic signed [VW-1:0]  clamped;

   always_comb begin
      nm      = (NM_W'(mant_ff) << 3) + (NM_W'(mant_ff) << 1) + NM_W'(dv_ff);
      top     = (opc_ff == CW'(1)) ? OP_END : op_rd_ff;
      mag_a   = a_ff[VW-1] ? (~a_ff + 1'b1) : a_ff;
      mag_b   = b_ff[VW-1] ? (~b_ff + 1'b1) : b_ff;
      sum_add = {a_ff[VW-1], a_ff} + {b_ff[VW-1], b_ff};
      sum_sub = {a_ff[VW-1], a_ff} - {b_ff[VW-1], b_ff};
      sat_add = (sum_add[VW] != sum_add[VW-1]) ? (sum_add[VW] ? VAL_MIN : VAL_MAX)
                                               : sum_add[VW-1:0];
      sat_sub = (sum_sub[VW] != sum_sub[VW-1]) ? (sum_sub[VW] ? VAL_MIN : VAL_MAX)
                                               : sum_sub[VW-1:0];
      dz_val  = (a_ff == '0) ? '0 : (a_ff[VW-1] ? VAL_MIN : VAL_MAX);
      push_en = cmd.conv_push | cmd.res_push;
      mdu_start = cmd.conv_start |
                  (cmd.alu_start && (top == OP_MUL || (top == OP_DIV && b_ff != '0)));
      mdu_mode  = (cmd.conv_start || top == OP_DIV) ? MD_DIV : MD_MUL;
      mdu_a     = cmd.conv_start ? DW'(mant_ff) : DW'(mag_a);
      mdu_b     = cmd.conv_start ? DW'(pow_ff) : DW'(mag_b);
      if (neg_ff) begin
         clamped = mdu_ge ? VAL_MIN : -$signed({1'b0, mdu_mag});
      end else begin
         clamped = mdu_ge ? VAL_MAX : $signed({1'b0, mdu_mag});
      end
   end

   always_comb begin
      stat.dv_bad      = dv_ff > 4'd9;
      stat.nm_ovf      = nm >= NM_W'(TEN_MAX);
      stat.fd_full     = point_ff && (fd_ff >= FD_W'(MAX_DIGITS));
      stat.point       = point_ff;
      stat.active      = active_ff;
      stat.op_full     = opc_ff == CW'(STACK_DEPTH);
      stat.num_full    = active_ff && (numc_ff == CW'(STACK_DEPTH));
      stat.parens_zero = parens_ff == '0;
      stat.res_rdy     = res_rdy_ff;
      stat.top         = top;
   end

   iee_mdu u_mdu (
      .clock (clock),
      .reset (reset),
      .start (mdu_start),
      .mode  (mdu_mode),
      .a_in  (mdu_a),
      .b_in  (mdu_b),
      .done  (mdu_done),
      .ge    (mdu_ge),
      .mag   (mdu_mag)
   );

   // number entry and counters
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         mant_ff   <= '0;
         pow_ff    <= MANT_W'(1);
         fd_ff     <= '0;
         point_ff  <= 1'b0;
         active_ff <= 1'b0;
         opc_ff    <= CW'(1);
         numc_ff   <= '0;
         parens_ff <= '0;
      end else begin
         if (cmd.digit_load) begin
            mant_ff   <= MANT_W'(nm);
            active_ff <= 1'b1;
            if (point_ff) begin
               fd_ff  <= fd_ff + 1'b1;
               pow_ff <= MANT_W'((pow_ff << 3) + (pow_ff << 1));
            end
         end
         if (cmd.point_set) begin
            point_ff <= 1'b1;
         end
         if (cmd.conv_push) begin
            mant_ff   <= '0;
            pow_ff    <= MANT_W'(1);
            fd_ff     <= '0;
            point_ff  <= 1'b0;
            active_ff <= 1'b0;
         end
         if (cmd.num_clear) begin
            numc_ff <= '0;
         end else if (push_en && numc_ff != CW'(STACK_DEPTH)) begin
            numc_ff <= numc_ff + 1'b1;
         end else if (cmd.num_pop && numc_ff != '0) begin
            numc_ff <= numc_ff - 1'b1;
         end
         if (cmd.op_push && opc_ff != CW'(STACK_DEPTH)) begin
            opc_ff <= opc_ff + 1'b1;
         end else if (cmd.op_pop && opc_ff > CW'(1)) begin
            opc_ff <= opc_ff - 1'b1;
         end
         if (cmd.paren_inc) begin
            parens_ff <= parens_ff + 1'b1;
         end else if (cmd.paren_dec) begin
            parens_ff <= parens_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op_push && opc_ff != CW'(STACK_DEPTH)) begin
         op_mem[opc_ff[AW-1:0]] <= cmd.tok;
      end
      if (cmd.top_read) begin
         op_rd_ff <= op_mem[AW'(opc_ff - 1'b1)];
      end
   end

   always_ff @(posedge clock) begin
      if (push_en && numc_ff != CW'(STACK_DEPTH)) begin
         num_mem[numc_ff[AW-1:0]] <= res_ff;
      end
      if (cmd.num_pop || cmd.num_peek) begin
         num_rd_ff <= num_mem[AW'(numc_ff - 1'b1)];
         empty_ff  <= numc_ff == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         dv_ff <= req_digit_value;
      end
      if (cmd.load_b) begin
         b_ff <= empty_ff ? '0 : num_rd_ff;
      end
      if (cmd.load_a) begin
         a_ff <= empty_ff ? '0 : num_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_rdy_ff <= 1'b0;
         dz_ff      <= 1'b0;
      end else begin
         if (cmd.take) begin
            dz_ff <= 1'b0;
         end
         if (cmd.conv_start) begin
            neg_ff     <= 1'b0;
            res_rdy_ff <= 1'b0;
         end
         if (cmd.alu_start) begin
            neg_ff <= a_ff[VW-1] ^ b_ff[VW-1];
            case (top)
               OP_ADD: begin
                  res_ff     <= sat_add;
                  res_rdy_ff <= 1'b1;
               end
               OP_SUB: begin
                  res_ff     <= sat_sub;
                  res_rdy_ff <= 1'b1;
               end
               OP_DIV: begin
                  if (b_ff == '0) begin
                     res_ff     <= dz_val;
                     res_rdy_ff <= 1'b1;
                     dz_ff      <= 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         if (mdu_done) begin
            res_ff     <= clamped;
            res_rdy_ff <= 1'b1;
         end
         if (push_en) begin
            res_rdy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         st_ff      <= (cmd.code == ST_OK && dz_ff) ? ST_DIVZERO : cmd.code;
         rv_ff      <= cmd.rsp_valid;
         val_ff     <= (cmd.rsp_valid && !empty_ff) ? num_rd_ff : '0;
         par_out_ff <= 6'(parens_ff);
      end
   end

   assign rsp_status           = st_ff;
   assign rsp_result_valid     = rv_ff;
   assign rsp_result_value     = val_ff;
   assign rsp_open_paren_count = par_out_ff;

endmodule

// ----- rtl/iee_ctrl.sv -----
// Controller: token checks and the precedence reduction sequencer.
// Depends on iee_pkg; drives iee_dp through command and status structs.
module iee_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [3:0]            req_kind,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   input  iee_pkg::dp_stat_type  stat,
   output iee_pkg::dp_cmd_type   cmd
);
   import iee_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_FLUSH, S_CONV_WAIT, S_TOP, S_DECIDE, S_POP_B, S_LOAD_B,
      S_POP_A, S_LOAD_A, S_APPLY, S_RES_WAIT, S_PEEK, S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      C_NONE, C_NUM, C_POINT, C_OP, C_LEFT, C_RIGHT, C_EQ
   } cls_type;

   state_type  state_ff, state_in;
   kind_type   kind_ff, kind_in;
   cls_type    cls_ff, cls_in;
   op_type     tok_ff, tok_in;
   status_type code_ff, code_in;
   logic       valid_ff, valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       after_val;
   rel_type    rel;

   always_comb begin
      after_val    = cls_ff == C_NUM || cls_ff == C_RIGHT || cls_ff == C_EQ;
      rel          = prec(stat.top, tok_ff);
      state_in     = state_ff;
      kind_in      = kind_ff;
      cls_in       = cls_ff;
      tok_in       = tok_ff;
      code_in      = code_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.code     = code_ff;
      cmd.rsp_valid = valid_ff;
      cmd.tok      = tok_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               kind_in  = kind_type'(req_kind);
               code_in  = ST_OK;
               valid_in = 1'b0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_FINISH;
            case (kind_ff)
               K_DIGIT: begin
                  if (cls_ff == C_RIGHT || stat.dv_bad || stat.nm_ovf || stat.fd_full) begin
                     code_in = ST_REJECT;
                  end else begin
                     cmd.digit_load = 1'b1;
                     cmd.num_clear  = cls_ff == C_EQ;
                     cls_in         = C_NUM;
                  end
               end
               K_POINT: begin
                  if (cls_ff != C_NUM || stat.point) begin
                     code_in = ST_REJECT;
                  end else begin
                     cmd.point_set = 1'b1;
                     cls_in        = C_POINT;
                  end
               end
               K_PLUS, K_MINUS, K_TIMES, K_DIVIDE: begin
                  if (!after_val) begin
                     code_in = ST_REJECT;
                  end else if (stat.num_full || stat.op_full) begin
                     code_in = ST_FULL;
                  end else begin
                     tok_in   = op_type'(3'(kind_ff) - 3'd2);
                     cls_in   = C_OP;
                     state_in = S_FLUSH;
                  end
               end
               K_LPAR: begin
                  if (cls_ff == C_NUM || cls_ff == C_POINT || after_val) begin
                     code_in = ST_REJECT;
                  end else if (stat.op_full) begin
                     code_in = ST_FULL;
                  end else begin
                     tok_in        = OP_LPAR;
                     cls_in        = C_LEFT;
                     cmd.paren_inc = 1'b1;
                     state_in      = S_TOP;
                  end
               end
               K_RPAR: begin
                  if ((cls_ff != C_NUM && cls_ff != C_RIGHT) || stat.parens_zero) begin
                     code_in = ST_REJECT;
                  end else if (stat.num_full) begin
                     code_in = ST_FULL;
                  end else begin
                     tok_in        = OP_RPAR;
                     cls_in        = C_RIGHT;
                     cmd.paren_dec = 1'b1;
                     state_in      = S_FLUSH;
                  end
               end
               K_EQUALS: begin
                  if (!after_val || !stat.parens_zero) begin
                     code_in = ST_REJECT;
                  end else if (stat.num_full) begin
                     code_in = ST_FULL;
                  end else begin
                     tok_in   = OP_END;
                     cls_in   = C_EQ;
                     valid_in = 1'b1;
                     state_in = S_FLUSH;
                  end
               end
               K_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  cls_in        = C_NONE;
               end
               default: begin
                  code_in = ST_REJECT;
               end
            endcase
         end
         S_FLUSH: begin
            if (stat.active) begin
               cmd.conv_start = 1'b1;
               state_in       = S_CONV_WAIT;
            end else begin
               state_in = S_TOP;
            end
         end
         S_CONV_WAIT: begin
            if (stat.res_rdy) begin
               cmd.conv_push = 1'b1;
               state_in      = S_TOP;
            end
         end
         S_TOP: begin
            cmd.top_read = 1'b1;
            state_in     = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = (tok_ff == OP_END) ? S_PEEK : S_FINISH;
            if (!(tok_ff == OP_END && stat.top == OP_END)) begin
               case (rel)
                  REL_LT: cmd.op_push = 1'b1;
                  REL_EQ: cmd.op_pop = 1'b1;
                  REL_GT: state_in = S_POP_B;
                  default: begin
                  end
               endcase
            end
         end
         S_POP_B: begin
            cmd.num_pop = 1'b1;
            state_in    = S_LOAD_B;
         end
         S_LOAD_B: begin
            cmd.load_b = 1'b1;
            state_in   = S_POP_A;
         end
         S_POP_A: begin
            cmd.num_pop = 1'b1;
            state_in    = S_LOAD_A;
         end
         S_LOAD_A: begin
            cmd.load_a = 1'b1;
            state_in   = S_APPLY;
         end
         S_APPLY: begin
            cmd.alu_start = 1'b1;
            cmd.op_pop    = 1'b1;
            state_in      = S_RES_WAIT;
         end
         S_RES_WAIT: begin
            if (stat.res_rdy) begin
               cmd.res_push = 1'b1;
               state_in     = S_TOP;
            end
         end
         S_PEEK: begin
            cmd.num_peek = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cls_ff       <= C_NONE;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= K_CLEAR;
         tok_ff       <= OP_END;
         code_ff      <= ST_OK;
         valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cls_ff       <= cls_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
         tok_ff       <= tok_in;
         code_ff      <= code_in;
         valid_ff     <= valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/infix_expression_evaluator.sv -----
// Infix calculator core: keypad tokens in, one response per token out.
// Requests take a token kind and digit value; every request yields exactly one
// response with status, result flag, fixed-point value (16 fraction bits) and
// the count of open left parentheses.
// One request is worked at a time. Digits, points, clear and rejected tokens
// go from the check straight to the finish state. An operator, right
// parenthesis or equals first converts the pending number (bit-serial divider),
// then runs the precedence reductions, one operator at a time; the conversion,
// multiply and divide share the one-bit-per-cycle multiply/divide unit, and add
// and subtract are done in the ALU. A long chain of pending reductions takes longer.
// The response sits in an output register: the next request is accepted while
// it waits, and a stalled receiver holds the next token in its finish state.
// Synchronous reset empties both stacks and the number entry; no clearing pass.
// Depends on iee_pkg, iee_if, iee_ctrl, iee_dp and the assertion macros.
`include "infix_expression_evaluator_macros.svh"

module infix_expression_evaluator #(
   parameter int STACK_DEPTH = 32
) (
   input logic      clock,
   input logic      reset,
   iee_req_if.sink  req_if,
   iee_rsp_if.source rsp_if
);
   import iee_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   iee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (req_if.kind),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   iee_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_digit_value      (req_if.digit_value),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_status           (rsp_if.status),
      .rsp_result_valid     (rsp_if.result_valid),
      .rsp_result_value     (rsp_if.result_value),
      .rsp_open_paren_count (rsp_if.open_paren_count)
   );

   `IEE_ASSERT_NXT(a_one_request, clock, reset, req_if.valid && req_if.ready, !req_if.ready, "request taken while busy")
   `IEE_ASSERT_IMP(a_result_status, clock, reset, rsp_if.valid && rsp_if.result_valid, rsp_if.status == ST_OK || rsp_if.status == ST_DIVZERO, "result flagged with bad status")
   `IEE_ASSERT_IMP(a_value_zero, clock, reset, rsp_if.valid && !rsp_if.result_valid, rsp_if.result_value == '0, "value without result")

endmodule

// ----- sim/infix_expression_evaluator_tb.sv -----
// Testbench for the infix expression evaluator: keypad token requests in,
// one response per request checked against a predictor of the two-stack evaluator.
// Depends on iee_pkg, iee_if and the infix_expression_evaluator top level.
`timescale 1ns / 1ps

module infix_expression_evaluator_tb;
   import iee_pkg::*;

   localparam int     DEPTH = 32;
   localparam longint VMAX  = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint VMIN  = -VMAX - 1;

   typedef enum int {TC_NONE, TC_NUM, TC_POINT, TC_OP, TC_LEFT, TC_RIGHT, TC_EQ} tok_class_type;

   typedef struct {
      logic [1:0]        status;
      logic              rv;
      logic signed [47:0] value;
      logic [5:0]        parens;
   } answer_type;

   typedef struct {
      logic [3:0] kind;
      logic [3:0] dv;
      bit         typed;
      answer_type ans;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   iee_req_if req_if ();
   iee_rsp_if rsp_if ();

   infix_expression_evaluator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // evaluator state
   op_type        op_stk [DEPTH];
   int            op_cnt;
   longint        num_stk [DEPTH];
   int            num_cnt;
   longint unsigned mant;
   bit            entry_on;
   int            frac_dig;
   bit            point_on;
   tok_class_type last_cls;
   int            paren_cnt;
   bit            div_zero;

   answer_type pending_answers[$];
   int         errors = 0;

   function automatic longint unsigned pow10(int n);
      longint unsigned p = 1;
      for (int k = 0; k < n; k++) p = p * 10;
      return p;
   endfunction

   function automatic void clear_state();
      op_stk[0] = OP_END;
      op_cnt    = 1;
      num_cnt   = 0;
      mant      = 0;
      entry_on  = 0;
      frac_dig  = 0;
      point_on  = 0;
      last_cls  = TC_NONE;
      paren_cnt = 0;
   endfunction

   function automatic longint sat_mag(bit neg, logic [127:0] mag);
      if (neg) return (mag >= 128'h8000_0000_0000) ? VMIN : -longint'(mag[63:0]);
      return (mag > 128'(VMAX)) ? VMAX : longint'(mag[63:0]);
   endfunction

   function automatic logic [127:0] mag_of(longint v);
      return (v < 0) ? 128'(-v) : 128'(v);
   endfunction

   function automatic longint fx_product(longint a, longint b);
      logic [127:0] p;
      p = mag_of(a) * mag_of(b) + (128'd1 << (FB - 1));
      return sat_mag((a < 0) != (b < 0), p >> FB);
   endfunction

   function automatic longint fx_quotient(longint a, longint b);
      logic [127:0] n, y, q, r;
      if (b == 0) begin
         div_zero = 1;
         return (a > 0) ? VMAX : ((a < 0) ? VMIN : 0);
      end
      y = mag_of(b);
      n = mag_of(a) << FB;
      q = n / y;
      r = n % y;
      if (q > (128'd1 << 50)) return sat_mag((a < 0) != (b < 0), {128{1'b1}});
      if (r >= y - r) q = q + 1;
      return sat_mag((a < 0) != (b < 0), q);
   endfunction

   function automatic longint combine(longint a, op_type op, longint b);
      longint s;
      case (op)
         OP_ADD: s = a + b;
         OP_SUB: s = a - b;
         OP_MUL: return fx_product(a, b);
         OP_DIV: return fx_quotient(a, b);
         default: return 0;
      endcase
      return (s > VMAX) ? VMAX : ((s < VMIN) ? VMIN : s);
   endfunction

   function automatic void push_value(longint v);
      if (num_cnt < DEPTH) begin
         num_stk[num_cnt] = v;
         num_cnt++;
      end
   endfunction

   function automatic longint pop_value();
      if (num_cnt == 0) return 0;
      num_cnt--;
      return num_stk[num_cnt];
   endfunction

   function automatic void reduce(op_type tok);
      op_type  top;
      rel_type rel;
      longint  a, b;
      forever begin
         top = (op_cnt > 0) ? op_stk[op_cnt - 1] : OP_END;
         if (tok == OP_END && top == OP_END) break;
         rel = prec(top, tok);
         if (rel == REL_LT) begin
            if (op_cnt < DEPTH) begin
               op_stk[op_cnt] = tok;
               op_cnt++;
            end
            break;
         end
         if (rel == REL_EQ) begin
            if (op_cnt > 1) op_cnt--;
            break;
         end
         if (rel != REL_GT) break;
         b = pop_value();
         a = pop_value();
         if (op_cnt > 0) op_cnt--;
         push_value(combine(a, top, b));
      end
   endfunction

   function automatic longint entry_fixed();
      longint unsigned d, q;
      logic [127:0]    r, frac, rr;
      d = pow10(frac_dig);
      q = mant / d;
      r = 128'(mant % d);
      if (q > (longint'(VMAX) >>> FB)) return VMAX;
      frac = (r << FB) / d;
      rr   = (r << FB) % d;
      if (rr >= d - rr) frac = frac + 1;
      return sat_mag(0, (128'(q) << FB) + frac);
   endfunction

   function automatic void flush_number();
      if (entry_on) begin
         push_value(entry_fixed());
         mant     = 0;
         entry_on = 0;
         frac_dig = 0;
         point_on = 0;
      end
   endfunction

   function automatic answer_type evaluate_token(logic [3:0] kind, logic [3:0] dv);
      answer_type      ans;
      bit              after_val, num_full;
      longint unsigned nm;
      ans       = '{status: ST_OK, rv: 0, value: 0, parens: 0};
      after_val = (last_cls == TC_NUM || last_cls == TC_RIGHT || last_cls == TC_EQ);
      num_full  = entry_on && num_cnt >= DEPTH;
      div_zero  = 0;
      case (kind)
         K_DIGIT: begin
            nm = mant * 10 + dv;
            if (last_cls == TC_RIGHT || dv > 9 || nm >= pow10(MAX_DIGITS) ||
                (point_on && frac_dig >= MAX_DIGITS)) begin
               ans.status = ST_REJECT;
            end else begin
               if (last_cls == TC_EQ) num_cnt = 0;
               mant     = nm;
               entry_on = 1;
               if (point_on) frac_dig++;
               last_cls = TC_NUM;
            end
         end
         K_POINT: begin
            if (last_cls != TC_NUM || point_on) ans.status = ST_REJECT;
            else begin
               point_on = 1;
               last_cls = TC_POINT;
            end
         end
         K_PLUS, K_MINUS, K_TIMES, K_DIVIDE: begin
            if (!after_val) ans.status = ST_REJECT;
            else if (num_full || op_cnt >= DEPTH) ans.status = ST_FULL;
            else begin
               flush_number();
               reduce(op_type'(kind - 4'd2));
               last_cls = TC_OP;
            end
         end
         K_LPAR: begin
            if (last_cls inside {TC_NUM, TC_POINT, TC_RIGHT, TC_EQ}) ans.status = ST_REJECT;
            else if (op_cnt >= DEPTH) ans.status = ST_FULL;
            else begin
               reduce(OP_LPAR);
               paren_cnt++;
               last_cls = TC_LEFT;
            end
         end
         K_RPAR: begin
            if ((last_cls != TC_NUM && last_cls != TC_RIGHT) || paren_cnt == 0)
               ans.status = ST_REJECT;
            else if (num_full) ans.status = ST_FULL;
            else begin
               flush_number();
               reduce(OP_RPAR);
               paren_cnt--;
               last_cls = TC_RIGHT;
            end
         end
         K_EQUALS: begin
            if (!after_val || paren_cnt != 0) ans.status = ST_REJECT;
            else if (num_full) ans.status = ST_FULL;
            else begin
               flush_number();
               reduce(OP_END);
               ans.rv    = 1;
               ans.value = (num_cnt > 0) ? num_stk[num_cnt - 1] : 0;
               last_cls  = TC_EQ;
            end
         end
         K_CLEAR: clear_state();
         default: ans.status = ST_REJECT;
      endcase
      if (div_zero && ans.status == ST_OK) ans.status = ST_DIVZERO;
      ans.parens = paren_cnt[5:0];
      return ans;
   endfunction

   // random token, mostly well formed given the current entry state
   task automatic pick_token(input bit deep, output logic [3:0] kind, output logic [3:0] dv);
      int r;
      r  = $urandom_range(0, 99);
      dv = ($urandom_range(0, 49) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      if (r < 4) begin
         kind = 4'($urandom_range(0, 15));
         dv   = 4'($urandom_range(0, 15));
      end else if (r < 6) begin
         kind = K_CLEAR;
      end else if (last_cls inside {TC_NONE, TC_OP, TC_LEFT}) begin
         kind = ($urandom_range(0, 99) < (deep ? 70 : 20)) ? K_LPAR : K_DIGIT;
      end else if (last_cls == TC_POINT) begin
         kind = K_DIGIT;
      end else begin
         r = $urandom_range(0, 99);
         if (last_cls == TC_NUM && r < 30) kind = K_DIGIT;
         else if (last_cls == TC_NUM && r < 36 && !point_on) kind = K_POINT;
         else if (last_cls == TC_EQ && r < 15) kind = K_DIGIT;
         else if (paren_cnt > 0 && r < (deep ? 50 : 60)) kind = K_RPAR;
         else if (r < 88) kind = 4'($urandom_range(K_PLUS, K_DIVIDE));
         else kind = K_EQUALS;
      end
   endtask

   int burst_left = 0;

   task automatic send(input logic [3:0] kind, input logic [3:0] dv, input bit typed,
                       input answer_type typed_ans);
      answer_type ans;
      int         gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 10);
      end
      req_if.valid       <= 1'b1;
      req_if.kind        <= kind;
      req_if.digit_value <= dv;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      ans = evaluate_token(kind, dv);
      pending_answers.push_back(typed ? typed_ans : ans);
      burst_left--;
      @(negedge clock);
   endtask

   // receiver stall pattern: ready duty cycle redrawn from 100, 75, 35 or 10 percent
   int ready_pct = 100;
   int ready_age = 0;
   always @(negedge clock) begin
      ready_age <= ready_age + 1;
      if (ready_age % 300 == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pct <= 100;
            1: ready_pct <= 75;
            2: ready_pct <= 35;
            default: ready_pct <= 10;
         endcase
      end
      rsp_if.ready <= ($urandom_range(0, 99) < ready_pct);
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response status=%0d value=%0d", $time,
                     rsp_if.status, rsp_if.result_value);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_if.status !== want.status || rsp_if.result_valid !== want.rv ||
                rsp_if.result_value !== want.value || rsp_if.open_paren_count !== want.parens)
            begin
               $display("%0t: expected st=%0d rv=%0d val=%0d par=%0d, got st=%0d rv=%0d val=%0d par=%0d",
                        $time, want.status, want.rv, want.value, want.parens,
                        rsp_if.status, rsp_if.result_valid, rsp_if.result_value,
                        rsp_if.open_paren_count);
               errors++;
            end
         end
      end
   end

   initial begin
      #12ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic answer_type ta(logic [1:0] st, logic rv, longint v, int p);
      return '{status: st, rv: rv, value: v[47:0], parens: p[5:0]};
   endfunction

   initial begin
      row_type    rows[$];
      answer_type none;
      logic [3:0] k, d;
      bit         deep;
      none = ta(ST_OK, 0, 0, 0);
      rows = '{
         '{K_EQUALS, 0, 1, ta(ST_REJECT, 0, 0, 0)},
         '{K_RPAR, 0, 1, ta(ST_REJECT, 0, 0, 0)},
         '{K_POINT, 0, 1, ta(ST_REJECT, 0, 0, 0)},
         '{4'hF, 4'hF, 1, ta(ST_REJECT, 0, 0, 0)},
         '{K_DIGIT, 4'd12, 1, ta(ST_REJECT, 0, 0, 0)},
         '{K_LPAR, 0, 1, ta(ST_OK, 0, 0, 1)},
         '{K_DIGIT, 9, 0, none},
         '{K_POINT, 0, 0, none},
         '{K_DIGIT, 5, 0, none},
         '{K_POINT, 0, 1, ta(ST_REJECT, 0, 0, 1)},
         '{K_DIVIDE, 0, 0, none},
         '{K_DIGIT, 0, 0, none},
         '{K_RPAR, 0, 1, ta(ST_DIVZERO, 0, 0, 0)},
         '{K_EQUALS, 0, 1, ta(ST_OK, 1, VMAX, 0)},
         '{K_TIMES, 0, 0, none},
         '{K_DIGIT, 2, 0, none},
         '{K_EQUALS, 0, 1, ta(ST_OK, 1, VMAX, 0)},
         '{K_MINUS, 0, 0, none},
         '{K_DIGIT, 3, 0, none},
         '{K_EQUALS, 0, 0, none},
         '{K_DIGIT, 7, 0, none},
         '{K_PLUS, 0, 0, none},
         '{K_DIGIT, 1, 0, none},
         '{K_EQUALS, 0, 1, ta(ST_OK, 1, 64'sd8 <<< FB, 0)},
         '{K_CLEAR, 0, 1, ta(ST_OK, 0, 0, 0)}
      };
      clear_state();
      req_if.valid       = 1'b0;
      req_if.kind        = K_CLEAR;
      req_if.digit_value = 4'd0;
      rsp_if.ready       = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) send(rows[i].kind, rows[i].dv, rows[i].typed, rows[i].ans);

      deep = 0;
      for (int n = 0; n < 1300; n++) begin
         if (n % 100 == 0) deep = ($urandom_range(0, 3) == 0);
         if (n == 650) begin
            req_if.valid <= 1'b0;
            burst_left = 0;
            while (pending_answers.size() != 0) @(negedge clock);
         end
         pick_token(deep, k, d);
         send(k, d, 0, none);
      end
      req_if.valid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
